// ===== sv/bsr_pkg.sv =====
package bsr_pkg;

	localparam int FRAC_BITS = 16;
	localparam int MAX_STEPS = 48;

	localparam int OPERAND_W = 32;
	localparam int ROOT_W    = 24;
	localparam int STATUS_W  = 2;
	localparam int TOL_W     = 16;

	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(7);

	localparam int MAG_W  = OPERAND_W - 1;
	localparam int SQ_W   = 2 * MAG_W;
	localparam int TGT_W  = MAG_W + FRAC_BITS;
	localparam int CMP_W  = ((SQ_W > TGT_W) ? SQ_W : TGT_W) + 2;
	localparam int STEP_W = $clog2(MAX_STEPS);

	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAX_STEPS - 1);
	localparam logic [MAG_W-1:0]  ONE_Q     = MAG_W'(1) << FRAC_BITS;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK    = 2'd0,
		STS_NEG   = 2'd1,
		STS_LIMIT = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SQR,
		S_CMP,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic square;
		logic compare;
		logic emit;
	} bsr_cmd_t;

	typedef struct packed {
		logic neg;
		logic hit;
		logic narrow;
	} bsr_sts_t;

endpackage

// ===== sv/bsr_op_if.sv =====
interface bsr_op_if import bsr_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [OPERAND_W-1:0] operand;

	modport source (output valid, output operand, input ready);
	modport sink   (input valid, input operand, output ready);
endinterface

// ===== sv/bsr_res_if.sv =====
interface bsr_res_if import bsr_pkg::*;;
	logic                valid;
	logic                ready;
	logic [ROOT_W-1:0]   root;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output root, output status, input ready);
	modport sink   (input valid, input root, input status, output ready);
endinterface

// ===== sv/bisection_square_root_unit.sv =====
// channel  dir  fields                      beat
// op       in   operand[31:0] signed Q16.16 valid & ready
// res      out  root[23:0] Q8.16, status[1:0] valid & ready
// cfg      in   cfg_wdata[15:0] tolerance   cfg_we
//
// Each bisection step squares the midpoint, then compares and narrows.
// A non-negative operand is loaded, then runs k steps, k at most 48, before it is emitted.
// A negative operand skips the steps; the next operand is taken after the result is
// loaded into the output register, which holds it until res.ready.
// arst_n clears the controller, the output valid and sets tolerance to 7.
module bisection_square_root_unit import bsr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [TOL_W-1:0] cfg_wdata,
	bsr_op_if.sink           op,
	bsr_res_if.source        res
);

	bsr_cmd_t cmd;
	bsr_sts_t sts;

	bsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (op.valid),
		.in_ready  (op.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bsr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.operand   (op.operand),
		.cmd       (cmd),
		.sts       (sts),
		.root      (res.root),
		.status    (res.status)
	);

endmodule

// ===== sv/bsr_ctrl.sv =====
module bsr_ctrl import bsr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  bsr_sts_t sts,
	output bsr_cmd_t cmd
);

	state_t            state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = sts.neg ? S_DONE : S_SQR;
				end
			end
			S_SQR: begin
				cmd.square = 1'b1;
				state_d    = S_CMP;
			end
			S_CMP: begin
				cmd.compare = 1'b1;
				if (sts.hit || sts.narrow || step_q == LAST_STEP) begin
					state_d = S_DONE;
				end else begin
					state_d = S_SQR;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// count midpoints tested
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.load) begin
			step_q <= '0;
		end else if (cmd.compare) begin
			step_q <= step_q + STEP_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_sqr_then_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SQR |=> state_q == S_CMP)
		else $error("square step not followed by compare");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CMP |-> step_q <= LAST_STEP)
		else $error("step count past limit");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("result overwrites pending beat");

	a_load_next: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_SQR || state_q == S_DONE))
		else $error("bad state after load");

endmodule

// ===== sv/bsr_dp.sv =====
module bsr_dp import bsr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [TOL_W-1:0]     cfg_wdata,
	input  logic [OPERAND_W-1:0] operand,
	input  bsr_cmd_t             cmd,
	output bsr_sts_t             sts,
	output logic [ROOT_W-1:0]    root,
	output logic [STATUS_W-1:0]  status
);

	logic [TOL_W-1:0]        tol_q;
	logic [MAG_W-1:0]        lo_q, hi_q, mid_q;
	logic [MAG_W-1:0]        cand_up_s1, cand_dn_s1;
	logic                    nar_up_s1, nar_dn_s1;
	logic [SQ_W-1:0]         sq_s1;
	logic signed [CMP_W-1:0] tgt_q, tlo_q, thi_q;
	logic [ROOT_W-1:0]       res_root_q, root_q;
	status_t                 res_status_q, status_q;

	logic [MAG_W-1:0]        x, hi_init;
	logic signed [CMP_W-1:0] tgt_in, tol_in, sq_ext;
	logic [MAG_W:0]          sum_up, sum_dn;
	logic                    below;
	logic [ROOT_W-1:0]       mid_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	assign x       = operand[MAG_W-1:0];
	assign hi_init = (x > ONE_Q) ? x : ONE_Q;
	assign tgt_in  = CMP_W'(x) << FRAC_BITS;
	assign tol_in  = CMP_W'(tol_q) << FRAC_BITS;

	assign sum_up = {1'b0, mid_q} + {1'b0, hi_q};
	assign sum_dn = {1'b0, lo_q} + {1'b0, mid_q};

	assign sq_ext = CMP_W'(sq_s1);
	assign below  = sq_ext < tgt_q;

	assign sts.neg    = operand[OPERAND_W-1];
	assign sts.hit    = (sq_ext > tlo_q) && (sq_ext < thi_q);
	assign sts.narrow = below ? nar_up_s1 : nar_dn_s1;

	assign mid_sat = (|mid_q[MAG_W-1:ROOT_W]) ? '1 : mid_q[ROOT_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lo_q  <= '0;
			hi_q  <= hi_init;
			mid_q <= hi_init >> 1;
			tgt_q <= tgt_in;
			tlo_q <= tgt_in - tol_in;
			thi_q <= tgt_in + tol_in;
			res_root_q   <= '0;
			res_status_q <= STS_NEG;
		end
		if (cmd.square) begin
			sq_s1      <= mid_q * mid_q;
			cand_up_s1 <= sum_up[MAG_W:1];
			cand_dn_s1 <= sum_dn[MAG_W:1];
			nar_up_s1  <= (hi_q - mid_q) <= MAG_W'(1);
			nar_dn_s1  <= (mid_q - lo_q) <= MAG_W'(1);
		end
		if (cmd.compare) begin
			res_root_q   <= mid_sat;
			res_status_q <= sts.hit ? STS_OK : STS_LIMIT;
			if (below) begin
				lo_q  <= mid_q;
				mid_q <= cand_up_s1;
			end else begin
				hi_q  <= mid_q;
				mid_q <= cand_dn_s1;
			end
		end
		if (cmd.emit) begin
			root_q   <= res_root_q;
			status_q <= res_status_q;
		end
	end

	assign root   = root_q;
	assign status = status_q;

	a_mid_inside: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.compare |-> (lo_q <= mid_q && mid_q <= hi_q))
		else $error("midpoint outside interval");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import bsr_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int LONG_HOLD   = 400;
	localparam int SETTLE      = 110;

	localparam logic [OPERAND_W-1:0] EDGE_OPERANDS [16] = '{
		32'h0000_0000, 32'h0000_0001, 32'h0000_0100, 32'h0000_FFFF,
		32'h0001_0000, 32'h0001_0001, 32'h0002_0000, 32'h0004_0000,
		32'h0009_0000, 32'h1234_5678, 32'h4000_0000, 32'h7FFF_FFFF,
		32'h8000_0000, 32'hFFFF_FFFF, 32'hC000_0000, 32'h5555_AAAA
	};

	typedef struct {
		logic [OPERAND_W-1:0] operand;
		logic [ROOT_W-1:0]    root;
		status_t              status;
	} root_beat_t;

	class root_checker;
		root_beat_t       due_roots[$];
		logic [TOL_W-1:0] tol;
		int               errors;

		function new();
			tol = TOL_RESET;
			errors = 0;
		endfunction

		function root_beat_t bisect_root(logic [OPERAND_W-1:0] x);
			root_beat_t  r;
			logic [63:0] lo, hi, mid, sq, target, gap, tol_q;
			logic        below;
			r.operand = x;
			r.root = '0;
			r.status = STS_LIMIT;
			if (x[OPERAND_W-1]) begin
				r.status = STS_NEG;
				return r;
			end
			lo = '0;
			hi = (64'(x) > (64'd1 << FRAC_BITS)) ? 64'(x) : (64'd1 << FRAC_BITS);
			target = 64'(x) << FRAC_BITS;
			tol_q = 64'(tol) << FRAC_BITS;
			mid = '0;
			for (int k = 0; k < MAX_STEPS; k++) begin
				mid = (lo + hi) >> 1;
				sq = mid * mid;
				below = sq < target;
				gap = below ? target - sq : sq - target;
				if (gap < tol_q) begin
					r.status = STS_OK;
					break;
				end
				if (below) begin
					lo = mid;
				end else begin
					hi = mid;
				end
				if (hi - lo <= 64'd1)
					break;
			end
			r.root = (mid > 64'hFF_FFFF) ? '1 : mid[ROOT_W-1:0];
			return r;
		endfunction

		function void note_operand(logic [OPERAND_W-1:0] x);
			due_roots.push_back(bisect_root(x));
		endfunction

		function void check_result(logic [ROOT_W-1:0] root, logic [STATUS_W-1:0] status);
			root_beat_t want;
			if (due_roots.size() == 0) begin
				$display("%0t: unexpected beat root=%h status=%0d", $time, root, status);
				errors++;
				return;
			end
			want = due_roots.pop_front();
			if (root !== want.root) begin
				$display("%0t: operand %h root expected %h actual %h",
					$time, want.operand, want.root, root);
				errors++;
			end
			if (status !== want.status) begin
				$display("%0t: operand %h status expected %0d actual %0d",
					$time, want.operand, want.status, status);
				errors++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [TOL_W-1:0] cfg_wdata;

	bsr_op_if  op_ch();
	bsr_res_if res_ch();

	root_checker book;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          hold_left;
	int          quiet;

	bisection_square_root_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.op        (op_ch),
		.res       (res_ch)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [OPERAND_W-1:0] pick_operand();
		logic [ROOT_W-1:0] r;
		logic [63:0]       sq;
		case ($urandom_range(0, 9))
			0, 1: pick_operand = $urandom | 32'h8000_0000;
			2, 3, 4: pick_operand = $urandom & 32'h7FFF_FFFF;
			5, 6: pick_operand = $urandom_range(0, 32'h0004_0000);
			7: pick_operand = 32'h0001_0000 + $urandom_range(0, 64) - 32;
			8: begin
				r = ROOT_W'($urandom_range(0, 24'hB504F0));
				sq = 64'(r) * 64'(r);
				pick_operand = 32'(sq >> FRAC_BITS);
			end
			default: pick_operand = EDGE_OPERANDS[4'($urandom_range(0, 15))];
		endcase
	endfunction

	task automatic offer_operand(input logic [OPERAND_W-1:0] x);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			op_ch.valid <= 1'b0;
			@(posedge clk);
		end
		op_ch.valid <= 1'b1;
		op_ch.operand <= x;
		@(posedge clk);
		while (!op_ch.ready)
			@(posedge clk);
		book.note_operand(x);
	endtask

	task automatic drain_roots();
		op_ch.valid <= 1'b0;
		while (book.due_roots.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_tolerance(input logic [TOL_W-1:0] v);
		drain_roots();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		book.tol = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_batch(input int n);
		repeat (n) offer_operand(pick_operand());
	endtask

	always @(posedge clk) begin
		if (res_ch.valid && res_ch.ready)
			book.check_result(res_ch.root, res_ch.status);
		if (hold_left > 0)
			hold_left = hold_left - 1;
		res_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if ((op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		book = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		op_ch.valid = 1'b0;
		op_ch.operand = '0;
		res_ch.ready = 1'b0;
		hold_left = 0;
		quiet = 0;
		send_idle_pct = 10;
		recv_idle_pct = 76;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (EDGE_OPERANDS[i])
			offer_operand(EDGE_OPERANDS[i]);

		write_tolerance('0);
		hold_left = LONG_HOLD;
		run_batch(150);
		write_tolerance('1);
		run_batch(150);

		send_idle_pct = 76;
		recv_idle_pct = 10;
		write_tolerance(TOL_W'($urandom_range(0, 65535)));
		run_batch(300);
		write_tolerance(TOL_W'(1));
		run_batch(100);
		drain_roots();
		run_batch(100);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_tolerance(TOL_RESET);
		run_batch(500);

		drain_roots();
		repeat (SETTLE) @(posedge clk);
		if (book.errors == 0 && book.due_roots.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
